FILE: rtl/rv32d_pkg.sv
// rv32d_pkg: opcodes, format and error codes, mnemonic indexes and the decode
// result type shared by the rv32 instruction decoder modules
// no dependencies
package rv32d_pkg;

	typedef logic [6:0] opcode_t;
	typedef logic [1:0] err_t;
	typedef logic [2:0] fmt_t;
	typedef logic [5:0] mnem_t;

	localparam opcode_t OPC_LOAD   = 7'h03;
	localparam opcode_t OPC_FENCE  = 7'h0F;
	localparam opcode_t OPC_IMM    = 7'h13;
	localparam opcode_t OPC_AUIPC  = 7'h17;
	localparam opcode_t OPC_STORE  = 7'h23;
	localparam opcode_t OPC_REG    = 7'h33;
	localparam opcode_t OPC_LUI    = 7'h37;
	localparam opcode_t OPC_BRANCH = 7'h63;
	localparam opcode_t OPC_JALR   = 7'h67;
	localparam opcode_t OPC_JAL    = 7'h6F;
	localparam opcode_t OPC_SYSTEM = 7'h73;

	localparam fmt_t FMT_R = 3'd0;
	localparam fmt_t FMT_I = 3'd1;
	localparam fmt_t FMT_S = 3'd2;
	localparam fmt_t FMT_B = 3'd3;
	localparam fmt_t FMT_U = 3'd4;
	localparam fmt_t FMT_J = 3'd5;

	localparam err_t ERR_NONE = 2'd0;
	localparam err_t ERR_OPC  = 2'd1;
	localparam err_t ERR_FUNC = 2'd2;

	// system call immediates
	localparam logic [11:0] SYS_ECALL  = 12'h000;
	localparam logic [11:0] SYS_EBREAK = 12'h001;
	localparam logic [11:0] SYS_URET   = 12'h002;
	localparam logic [11:0] SYS_SRET   = 12'h102;
	localparam logic [11:0] SYS_MRET   = 12'h302;

	localparam mnem_t MN_LUI    = 6'd0;
	localparam mnem_t MN_AUIPC  = 6'd1;
	localparam mnem_t MN_MUL    = 6'd2;
	localparam mnem_t MN_SUB    = 6'd10;
	localparam mnem_t MN_ADD    = 6'd11;
	localparam mnem_t MN_SLL    = 6'd12;
	localparam mnem_t MN_SLT    = 6'd13;
	localparam mnem_t MN_SLTU   = 6'd14;
	localparam mnem_t MN_XOR    = 6'd15;
	localparam mnem_t MN_SRA    = 6'd16;
	localparam mnem_t MN_SRL    = 6'd17;
	localparam mnem_t MN_OR     = 6'd18;
	localparam mnem_t MN_AND    = 6'd19;
	localparam mnem_t MN_ADDI   = 6'd20;
	localparam mnem_t MN_SLLI   = 6'd21;
	localparam mnem_t MN_SLTI   = 6'd22;
	localparam mnem_t MN_SLTIU  = 6'd23;
	localparam mnem_t MN_XORI   = 6'd24;
	localparam mnem_t MN_SRAI   = 6'd25;
	localparam mnem_t MN_SRLI   = 6'd26;
	localparam mnem_t MN_ORI    = 6'd27;
	localparam mnem_t MN_ANDI   = 6'd28;
	localparam mnem_t MN_BEQ    = 6'd29;
	localparam mnem_t MN_BNE    = 6'd30;
	localparam mnem_t MN_BLT    = 6'd31;
	localparam mnem_t MN_BGE    = 6'd32;
	localparam mnem_t MN_BLTU   = 6'd33;
	localparam mnem_t MN_BGEU   = 6'd34;
	localparam mnem_t MN_JAL    = 6'd35;
	localparam mnem_t MN_JALR   = 6'd36;
	localparam mnem_t MN_LB     = 6'd37;
	localparam mnem_t MN_SB     = 6'd44;
	localparam mnem_t MN_ECALL  = 6'd48;
	localparam mnem_t MN_EBREAK = 6'd49;
	localparam mnem_t MN_URET   = 6'd50;
	localparam mnem_t MN_SRET   = 6'd51;
	localparam mnem_t MN_MRET   = 6'd52;
	localparam mnem_t MN_CSRRW  = 6'd53;
	localparam mnem_t MN_CSRRS  = 6'd54;
	localparam mnem_t MN_CSRRC  = 6'd55;
	localparam mnem_t MN_CSRRWI = 6'd56;
	localparam mnem_t MN_CSRRSI = 6'd57;
	localparam mnem_t MN_CSRRCI = 6'd58;
	localparam mnem_t MN_FENCE  = 6'd59;

	typedef struct packed {
		err_t        error_code;
		fmt_t        format_class;
		mnem_t       mnemonic_index;
		logic [4:0]  dest_reg;
		logic        dest_used;
		logic [4:0]  src1_reg;
		logic        src1_used;
		logic [4:0]  src2_reg;
		logic        src2_used;
		logic [2:0]  funct3_field;
		logic [6:0]  funct7_field;
		logic [31:0] immediate;
	} dec_t;

endpackage

FILE: rtl/rv32d_decode.sv
// rv32d_decode: combinational decode of one rv32 instruction word into a dec_t
// depends on rv32d_pkg
module rv32d_decode
	import rv32d_pkg::*;
(
	input  logic [31:0] word,
	output dec_t        dec
);

	opcode_t     opc;
	logic [4:0]  rd;
	logic [2:0]  f3;
	logic [4:0]  rs1;
	logic [4:0]  rs2;
	logic [6:0]  f7;
	logic [11:0] imm12;
	logic        bad_func;
	mnem_t       mn;
	dec_t        d;

	assign opc   = word[6:0];
	assign rd    = word[11:7];
	assign f3    = word[14:12];
	assign rs1   = word[19:15];
	assign rs2   = word[24:20];
	assign f7    = word[31:25];
	assign imm12 = word[31:20];

	always_comb begin
		d        = '0;
		mn       = '0;
		bad_func = 1'b0;
		unique case (opc)
			OPC_REG: begin
				d.format_class = FMT_R;
				d.dest_reg     = rd;
				d.src1_reg     = rs1;
				d.src2_reg     = rs2;
				d.funct3_field = f3;
				d.funct7_field = f7;
				d.dest_used    = 1'b1;
				d.src1_used    = 1'b1;
				d.src2_used    = 1'b1;
				if (f7[0]) begin
					mn = MN_MUL + {3'b000, f3};
				end else begin
					unique case (f3)
						3'd0:    mn = (f7 != 7'd0) ? MN_SUB : MN_ADD;
						3'd1:    mn = MN_SLL;
						3'd2:    mn = MN_SLT;
						3'd3:    mn = MN_SLTU;
						3'd4:    mn = MN_XOR;
						3'd5:    mn = f7[5] ? MN_SRA : MN_SRL;
						3'd6:    mn = MN_OR;
						default: mn = MN_AND;
					endcase
				end
			end
			OPC_IMM, OPC_LOAD, OPC_JALR, OPC_SYSTEM, OPC_FENCE: begin
				d.format_class = FMT_I;
				d.dest_reg     = rd;
				d.src1_reg     = rs1;
				d.funct3_field = f3;
				d.funct7_field = f7;
				d.dest_used    = 1'b1;
				d.src1_used    = 1'b1;
				d.immediate    = {{20{imm12[11]}}, imm12};
				unique case (opc)
					OPC_IMM: begin
						unique case (f3)
							3'd0:    mn = MN_ADDI;
							3'd1:    mn = MN_SLLI;
							3'd2:    mn = MN_SLTI;
							3'd3:    mn = MN_SLTIU;
							3'd4:    mn = MN_XORI;
							3'd5:    mn = f7[5] ? MN_SRAI : MN_SRLI;
							3'd6:    mn = MN_ORI;
							default: mn = MN_ANDI;
						endcase
					end
					OPC_LOAD: begin
						if (f3 == 3'd7) bad_func = 1'b1;
						else mn = MN_LB + {3'b000, f3};
					end
					OPC_JALR: begin
						mn = MN_JALR;
					end
					OPC_FENCE: begin
						d.immediate = {20'd0, imm12};
						d.dest_used = 1'b0;
						d.src1_used = 1'b0;
						mn          = MN_FENCE;
					end
					default: begin
						// system: privileged calls or csr access
						d.immediate = {20'd0, imm12};
						unique case (f3)
							3'd0: begin
								d.dest_used = 1'b0;
								d.src1_used = 1'b0;
								unique case (imm12)
									SYS_ECALL:  mn = MN_ECALL;
									SYS_EBREAK: mn = MN_EBREAK;
									SYS_URET:   mn = MN_URET;
									SYS_SRET:   mn = MN_SRET;
									SYS_MRET:   mn = MN_MRET;
									default:    bad_func = 1'b1;
								endcase
							end
							3'd1: mn = MN_CSRRW;
							3'd2: mn = MN_CSRRS;
							3'd3: mn = MN_CSRRC;
							3'd4: bad_func = 1'b1;
							3'd5: begin
								mn          = MN_CSRRWI;
								d.src1_used = 1'b0;
							end
							3'd6: begin
								mn          = MN_CSRRSI;
								d.src1_used = 1'b0;
							end
							default: begin
								mn          = MN_CSRRCI;
								d.src1_used = 1'b0;
							end
						endcase
					end
				endcase
			end
			OPC_STORE: begin
				d.format_class = FMT_S;
				d.src1_reg     = rs1;
				d.src2_reg     = rs2;
				d.funct3_field = f3;
				d.src1_used    = 1'b1;
				d.src2_used    = 1'b1;
				d.immediate    = {{20{f7[6]}}, f7, rd};
				if (f3[2]) bad_func = 1'b1;
				else mn = MN_SB + {3'b000, f3};
			end
			OPC_BRANCH: begin
				d.format_class = FMT_B;
				d.src1_reg     = rs1;
				d.src2_reg     = rs2;
				d.funct3_field = f3;
				d.src1_used    = 1'b1;
				d.src2_used    = 1'b1;
				d.immediate    = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
				unique case (f3)
					3'd0:    mn = MN_BEQ;
					3'd1:    mn = MN_BNE;
					3'd4:    mn = MN_BLT;
					3'd5:    mn = MN_BGE;
					3'd6:    mn = MN_BLTU;
					3'd7:    mn = MN_BGEU;
					default: bad_func = 1'b1;
				endcase
			end
			OPC_LUI, OPC_AUIPC: begin
				d.format_class = FMT_U;
				d.dest_reg     = rd;
				d.dest_used    = 1'b1;
				d.immediate    = {word[31:12], 12'd0};
				mn             = (opc == OPC_LUI) ? MN_LUI : MN_AUIPC;
			end
			OPC_JAL: begin
				d.format_class = FMT_J;
				d.dest_reg     = rd;
				d.dest_used    = 1'b1;
				d.immediate    = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
				mn             = MN_JAL;
			end
			default: begin
				d.error_code = ERR_OPC;
			end
		endcase

		if (d.error_code != ERR_OPC) begin
			if (bad_func) begin
				d.error_code     = ERR_FUNC;
				d.mnemonic_index = '0;
			end else begin
				d.mnemonic_index = mn;
			end
		end
	end

	assign dec = d;

endmodule

FILE: rtl/rv32_instruction_decoder_core.sv
// rv32_instruction_decoder_core: top level of the rv32im instruction decoder,
// input register, decode logic and result register
// depends on rv32d_pkg and rv32d_decode
//
// usage
// - input channel: instr_word with in_valid / in_stall; a word is taken at a
//   rising edge with in_valid high and in_stall low
// - output channel: the decoded fields with out_valid / out_stall; a result
//   word is taken at a rising edge with out_valid high and out_stall low
// - one result word per instruction word, in order
// - a word goes from the input register through the decode cone into the
//   result register, and out_valid rises when the result register takes
//   its decoded word
// - throughput: one word per cycle while out_stall is low, set by the single
//   decode pass between the input and result registers
// - when out_stall is held, the result register holds its word and the input
//   register still takes one more word; in_stall rises once both are full
// - arst_n clears both valid flags; no words are held after reset
module rv32_instruction_decoder_core
	import rv32d_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        instr_word,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         error_code,
	output logic [2:0]         format_class,
	output logic [5:0]         mnemonic_index,
	output logic [4:0]         dest_reg,
	output logic               dest_used,
	output logic [4:0]         src1_reg,
	output logic               src1_used,
	output logic [4:0]         src2_reg,
	output logic               src2_used,
	output logic [2:0]         funct3_field,
	output logic [6:0]         funct7_field,
	output logic signed [31:0] immediate
);

	logic        valid_s1;
	logic [31:0] word_s1;
	logic        valid_s2;
	dec_t        res_s2;
	dec_t        dec;
	logic        adv_s2;
	logic        adv_s1;

	// a stage moves on when the one after it is empty or draining
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instr_word;
		end
	end

	rv32d_decode u_decode (
		.word (word_s1),
		.dec  (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec;
		end
	end

	assign out_valid      = valid_s2;
	assign error_code     = res_s2.error_code;
	assign format_class   = res_s2.format_class;
	assign mnemonic_index = res_s2.mnemonic_index;
	assign dest_reg       = res_s2.dest_reg;
	assign dest_used      = res_s2.dest_used;
	assign src1_reg       = res_s2.src1_reg;
	assign src1_used      = res_s2.src1_used;
	assign src2_reg       = res_s2.src2_reg;
	assign src2_used      = res_s2.src2_used;
	assign funct3_field   = res_s2.funct3_field;
	assign funct7_field   = res_s2.funct7_field;
	assign immediate      = $signed(res_s2.immediate);

`ifndef SYNTHESIS
	// input only stalls when both registers hold a word and the output is held
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall without a full pipeline");

	// unknown opcode clears the rest of the word
	a_opc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_OPC) |->
		(format_class == FMT_R && mnemonic_index == '0 && immediate == '0 &&
		 !dest_used && !src1_used && !src2_used))
		else $error("unknown opcode word not cleared");

	// unknown function reports mnemonic zero
	a_func_mn: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error_code == ERR_FUNC) |-> (mnemonic_index == '0))
		else $error("unknown function with nonzero mnemonic");

	// stores and branches write no register
	a_sb_no_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (format_class == FMT_S || format_class == FMT_B)) |->
		(!dest_used && dest_reg == '0 && funct7_field == '0))
		else $error("store or branch with destination");

	// upper immediate and jal read no registers
	a_uj_no_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (format_class == FMT_U || format_class == FMT_J)) |->
		(!src1_used && !src2_used && funct3_field == '0))
		else $error("u or j format with source operand");
`endif

endmodule
